// ===== hdl/icov_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icov_pkg: shared types and constants for the interval point cover unit
// Holds the request and result payloads, the stored entry layout, the
// operand bundle of the shared comparator and the sequencer state codes.
// ----------------------------------------------------------------------------
package icov_pkg;

  // Capacity of the segment store and the widths that follow from it.
  localparam int MAX_SEGMENTS = 64;
  localparam int ADDR_W       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int COORD_W      = 32;
  localparam int PIDX_W       = 6;

  // One incoming segment request.
  typedef struct packed {
    logic signed [COORD_W-1:0] seg_start;
    logic signed [COORD_W-1:0] seg_end;
    logic                      last_segment;
  } seg_req_t;

  // One outgoing covering point.
  typedef struct packed {
    logic signed [COORD_W-1:0] point;
    logic [PIDX_W-1:0]         point_index;
    logic                      last_point;
    logic                      overflow;
  } pt_res_t;

  // One store entry: left and right end of a segment. During the scan the
  // right end of the lower entries is reused to hold the chosen points.
  typedef struct packed {
    logic signed [COORD_W-1:0] lo;
    logic signed [COORD_W-1:0] hi;
  } entry_t;

  // Operands of the shared comparator: it reports a0 < b0 or a1 < b1.
  typedef struct packed {
    logic signed [COORD_W-1:0] a0;
    logic signed [COORD_W-1:0] b0;
    logic signed [COORD_W-1:0] a1;
    logic signed [COORD_W-1:0] b1;
  } cmp_req_t;

  // Sequencer states.
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SHIFT   = 7'b0000010,
    ST_PUT     = 7'b0000100,
    ST_SCAN_RD = 7'b0001000,
    ST_SCAN    = 7'b0010000,
    ST_EMIT    = 7'b0100000,
    ST_EMIT_LD = 7'b1000000
  } state_t;

endpackage

// ===== hdl/icov_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icov_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module icov_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/icov_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icov_cmp: shared signed comparator
// Serves both the insertion walk and the greedy scan.
// ----------------------------------------------------------------------------
module icov_cmp import icov_pkg::*; (
  input  cmp_req_t req,
  output logic     hit
);

  // Two signed less-than checks, either of which raises the flag.
  assign hit = (req.a0 < req.b0) || (req.a1 < req.b1);

endmodule

// ===== hdl/interval_point_cover_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_point_cover_unit: greedy covering of segments by points
// Collects closed segments into a store sorted by right end (ties in arrival
// order), then scans the store greedily and returns the chosen points.
//
//   Channel  Direction  Handshake            Payload
//   seg      in         seg_valid/seg_ready  seg_req_t (start, end, last)
//   pt       out        pt_valid/pt_ready    pt_res_t (point, index, flags)
//
// A segment is put in by a walk down the store past the entries with a larger
// right end; the insertion walk does one RAM read and one write per cycle.
// A full store drops the segment and sets the overflow flag.
// The request marked last then starts a scan over the stored entries, and the
// chosen points are emitted after it, stalling while pt_ready is low.
// Reset clears the count, the flag, the sequencer and pt_valid; the store needs none.
// New segments are taken once the final point sits in the output register.
// ----------------------------------------------------------------------------
module interval_point_cover_unit import icov_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     seg_valid,
  output logic     seg_ready,
  input  seg_req_t seg,
  output logic     pt_valid,
  input  logic     pt_ready,
  output pt_res_t  pt
);

  state_t                    state, state_next;
  logic [CNT_W-1:0]          seg_count, seg_count_next;
  logic                      ovf, ovf_next;
  logic [ADDR_W-1:0]         pos, pos_next;
  entry_t                    new_ent, new_ent_next;
  logic                      is_last, is_last_next;
  logic [ADDR_W-1:0]         sidx, sidx_next;
  logic [CNT_W-1:0]          npts, npts_next;
  logic signed [COORD_W-1:0] cur, cur_next;
  logic [ADDR_W-1:0]         eidx, eidx_next;
  logic                      pt_load;
  logic                      pt_last;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  entry_t            wr_data, rd_data;
  cmp_req_t          cmp_req;
  logic              cmp_hit;

  // Segment store.
  icov_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_SEGMENTS)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Shared comparator.
  icov_cmp u_cmp (
    .req(cmp_req),
    .hit(cmp_hit)
  );

  assign seg_ready = (state == ST_IDLE);
  assign pt_last   = ((CNT_W'(eidx) + CNT_W'(1)) == npts);

  // Sequencer and datapath control.
  always_comb begin
    state_next     = state;
    seg_count_next = seg_count;
    ovf_next       = ovf;
    pos_next       = pos;
    new_ent_next   = new_ent;
    is_last_next   = is_last;
    sidx_next      = sidx;
    npts_next      = npts;
    cur_next       = cur;
    eidx_next      = eidx;
    pt_load        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = pos;
    wr_data        = new_ent;
    rd_en          = 1'b0;
    rd_addr        = '0;
    // Insertion: the stored entry moves up when its right end is larger.
    cmp_req.a0     = new_ent.hi;
    cmp_req.b0     = rd_data.hi;
    cmp_req.a1     = '0;
    cmp_req.b1     = '0;

    case (state)
      ST_IDLE: begin
        if (seg_valid) begin
          if (seg_count == CNT_W'(MAX_SEGMENTS)) begin
            ovf_next = 1'b1;
            if (seg.last_segment) begin
              state_next = ST_SCAN_RD;
            end
          end else begin
            new_ent_next.lo = seg.seg_start;
            new_ent_next.hi = seg.seg_end;
            is_last_next    = seg.last_segment;
            pos_next        = seg_count[ADDR_W-1:0];
            if (seg_count == '0) begin
              state_next = ST_PUT;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = ADDR_W'(seg_count - CNT_W'(1));
              state_next = ST_SHIFT;
            end
          end
        end
      end

      ST_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = pos;
        if (cmp_hit) begin
          // Entry below is larger: move it up one place and keep walking.
          wr_data  = rd_data;
          pos_next = pos - ADDR_W'(1);
          if (pos == ADDR_W'(1)) begin
            state_next = ST_PUT;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos - ADDR_W'(2);
          end
        end else begin
          wr_data        = new_ent;
          seg_count_next = seg_count + CNT_W'(1);
          state_next     = is_last ? ST_SCAN_RD : ST_IDLE;
        end
      end

      ST_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = pos;
        wr_data        = new_ent;
        seg_count_next = seg_count + CNT_W'(1);
        state_next     = is_last ? ST_SCAN_RD : ST_IDLE;
      end

      ST_SCAN_RD: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        sidx_next  = '0;
        npts_next  = '0;
        state_next = ST_SCAN;
      end

      ST_SCAN: begin
        // A new point is needed when the current one lies outside the segment.
        cmp_req.a0 = cur;
        cmp_req.b0 = rd_data.lo;
        cmp_req.a1 = rd_data.hi;
        cmp_req.b1 = cur;
        if (sidx == '0) begin
          cur_next  = rd_data.hi;
          npts_next = CNT_W'(1);
        end else if (cmp_hit) begin
          cur_next  = rd_data.hi;
          wr_en     = 1'b1;
          wr_addr   = npts[ADDR_W-1:0];
          wr_data   = rd_data;
          npts_next = npts + CNT_W'(1);
        end
        if ((CNT_W'(sidx) + CNT_W'(1)) == seg_count) begin
          eidx_next  = '0;
          state_next = ST_EMIT;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = sidx + ADDR_W'(1);
          sidx_next = sidx + ADDR_W'(1);
        end
      end

      ST_EMIT: begin
        // Fetch the next point once the output register will be free.
        if (!pt_valid || pt_ready) begin
          rd_en      = 1'b1;
          rd_addr    = eidx;
          state_next = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        pt_load = 1'b1;
        if (pt_last) begin
          seg_count_next = '0;
          ovf_next       = 1'b0;
          state_next     = ST_IDLE;
        end else begin
          eidx_next  = eidx + ADDR_W'(1);
          state_next = ST_EMIT;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seg_count <= '0;
      ovf       <= 1'b0;
      pt_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      seg_count <= seg_count_next;
      ovf       <= ovf_next;
      if (pt_load) begin
        pt_valid <= 1'b1;
      end else if (pt_ready) begin
        pt_valid <= 1'b0;
      end
    end
  end

  // Working and output registers.
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    new_ent <= new_ent_next;
    is_last <= is_last_next;
    sidx    <= sidx_next;
    npts    <= npts_next;
    cur     <= cur_next;
    eidx    <= eidx_next;
    if (pt_load) begin
      pt.point       <= rd_data.hi;
      pt.point_index <= PIDX_W'(eidx);
      pt.last_point  <= pt_last;
      pt.overflow    <= ovf;
    end
  end

  // The stored count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count beyond capacity");

  // A simultaneous read and write never touch the same entry.
  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write at the same store address");

  // A point is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    pt_load |-> !pt_valid)
    else $error("output register overwritten");

  // During the scan the point count never runs ahead of the entries read.
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (npts <= CNT_W'(sidx)))
    else $error("scan point count ahead of scan index");

  // Leaving the emit phase always clears the count for a new set.
  a_run_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT_LD && pt_last) |=> (seg_count == '0 && !ovf))
    else $error("run not cleared after final point");

endmodule
